// File: design/tfm_pkg.sv
`timescale 1ns / 1ps
// Package for the temperature fusion monitor: widths, codes, pipeline stage map,
// shared structs and the thermistor calibration table. Depends on nothing.

package tfm_pkg;

  localparam int TEMP_W     = 14;
  localparam int NTC_TEMP_W = 13;
  localparam int CODE_W     = 12;
  localparam int SEG_W      = 5;
  localparam int PT_IDX_W   = 6;
  localparam int DIFF_W     = 8;
  localparam int NUM_W      = 15;
  localparam int QUO_W      = 8;
  localparam int CFG_W      = 14;
  localparam int CFG_IDX_W  = 2;

  localparam int NTC_POINTS = 33;
  localparam int NTC_SEGS   = NTC_POINTS - 1;

  localparam logic [CODE_W-1:0] NTC_CODE_MIN  = 12'd0;
  localparam logic [CODE_W-1:0] NTC_CODE_MAX  = 12'd4095;
  localparam logic [CODE_W-1:0] NTC_TABLE_TOP = 12'd3222;
  localparam logic [CODE_W-1:0] NTC_TABLE_BOT = 12'd204;

  localparam logic signed [NTC_TEMP_W-1:0] NTC_COLD_T = -13'sd1280;
  localparam logic signed [NTC_TEMP_W-1:0] NTC_HOT_T  = 13'sd3840;

  localparam logic signed [CFG_W-1:0] WARN_RESET   = 14'sd1920;
  localparam logic signed [CFG_W-1:0] CRIT_RESET   = 14'sd2400;
  localparam logic [CFG_W-1:0]        SPREAD_RESET = 14'd160;

  // Divider: two quotient bits per register stage.
  localparam int DIV_BITS_PER_STAGE = 2;
  localparam int DIV_STAGES         = QUO_W / DIV_BITS_PER_STAGE;

  // Pipeline stage map.
  localparam int ST_SEARCH = 0;
  localparam int ST_LOOKUP = 1;
  localparam int ST_DIV0   = 2;
  localparam int ST_FINAL  = ST_DIV0 + DIV_STAGES;
  localparam int ST_MINMAX = ST_FINAL + 1;
  localparam int ST_OUT    = ST_MINMAX + 1;
  localparam int NUM_STAGES = ST_OUT + 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WARN   = 2'd0,
    CFG_CRIT   = 2'd1,
    CFG_SPREAD = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ALARM_NORMAL = 2'd0,
    ALARM_WARN   = 2'd1,
    ALARM_CRIT   = 2'd2
  } alarm_t;

  typedef struct packed {
    logic             valid;
    logic             cold;
    logic             hot;
    logic [SEG_W-1:0] lo;
  } ntc_side_t;

  typedef struct packed {
    logic [NUM_W-1:0]  num;
    logic [DIFF_W-1:0] dvsr;
    ntc_side_t         side;
  } front_out_t;

  typedef struct packed {
    logic [NUM_W-1:0]  rem;
    logic [DIFF_W-1:0] dvsr;
    logic [QUO_W-1:0]  quo;
    ntc_side_t         side;
  } div_word_t;

  typedef struct packed {
    logic signed [TEMP_W-1:0] dig;
    logic signed [TEMP_W-1:0] die;
  } src_temps_t;

  // Thermistor ADC code at each 5 degC point, -40 degC first.
  function automatic logic [CODE_W-1:0] ntc_point(input logic [PT_IDX_W-1:0] idx);
    logic [CODE_W-1:0] v;
    case (idx)
      6'd0:  v = 12'd3222;
      6'd1:  v = 12'd3195;
      6'd2:  v = 12'd3161;
      6'd3:  v = 12'd3118;
      6'd4:  v = 12'd3064;
      6'd5:  v = 12'd2998;
      6'd6:  v = 12'd2919;
      6'd7:  v = 12'd2825;
      6'd8:  v = 12'd2716;
      6'd9:  v = 12'd2592;
      6'd10: v = 12'd2455;
      6'd11: v = 12'd2306;
      6'd12: v = 12'd2147;
      6'd13: v = 12'd1983;
      6'd14: v = 12'd1816;
      6'd15: v = 12'd1650;
      6'd16: v = 12'd1489;
      6'd17: v = 12'd1335;
      6'd18: v = 12'd1190;
      6'd19: v = 12'd1056;
      6'd20: v = 12'd934;
      6'd21: v = 12'd824;
      6'd22: v = 12'd725;
      6'd23: v = 12'd637;
      6'd24: v = 12'd560;
      6'd25: v = 12'd492;
      6'd26: v = 12'd432;
      6'd27: v = 12'd380;
      6'd28: v = 12'd335;
      6'd29: v = 12'd295;
      6'd30: v = 12'd260;
      6'd31: v = 12'd230;
      6'd32: v = 12'd204;
      default: v = 12'd0;
    endcase
    return v;
  endfunction

endpackage

// File: design/tfm_ntc_front.sv
`timescale 1ns / 1ps
// Thermistor front end: table segment search and segment lookup, two stages.
// Depends on tfm_pkg.

module tfm_ntc_front (
  input  logic                        clk,
  input  logic [1:0]                  stage_en,
  input  logic [tfm_pkg::CODE_W-1:0]  code,
  output tfm_pkg::front_out_t         fout
);

  logic [tfm_pkg::CODE_W-1:0] code_r;
  tfm_pkg::ntc_side_t         side_r;
  tfm_pkg::ntc_side_t         side_nxt;
  logic [tfm_pkg::NTC_SEGS:0] gt;
  tfm_pkg::front_out_t        fout_r;
  tfm_pkg::front_out_t        fout_nxt;

  // Search: the table falls, so the entries above the code form a prefix and
  // the segment start is the last entry of that prefix.
  always_comb begin
    for (int i = 0; i <= tfm_pkg::NTC_SEGS; i++) begin
      gt[i] = tfm_pkg::ntc_point(tfm_pkg::PT_IDX_W'(i)) > code;
    end
    side_nxt.lo = '0;
    for (int i = 1; i < tfm_pkg::NTC_SEGS; i++) begin
      if (gt[i] && !gt[i+1]) begin
        side_nxt.lo = side_nxt.lo | tfm_pkg::SEG_W'(i);
      end
    end
    side_nxt.valid = (code != tfm_pkg::NTC_CODE_MIN) && (code != tfm_pkg::NTC_CODE_MAX);
    side_nxt.cold  = code > tfm_pkg::NTC_TABLE_TOP;
    side_nxt.hot   = code < tfm_pkg::NTC_TABLE_BOT;
  end

  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      code_r <= code;
      side_r <= side_nxt;
    end
  end

  // Lookup: segment end points, distance into the segment and its width.
  always_comb begin
    logic [tfm_pkg::CODE_W-1:0] t_lo;
    logic [tfm_pkg::CODE_W-1:0] t_hi;
    logic [tfm_pkg::DIFF_W-1:0] dval;
    t_lo = tfm_pkg::ntc_point({1'b0, side_r.lo});
    t_hi = tfm_pkg::ntc_point(tfm_pkg::PT_IDX_W'(side_r.lo) + 6'd1);
    dval = tfm_pkg::DIFF_W'(t_lo - code_r);
    fout_nxt.dvsr = tfm_pkg::DIFF_W'(t_lo - t_hi);
    fout_nxt.num  = tfm_pkg::NUM_W'({dval, 7'b0}) + tfm_pkg::NUM_W'({dval, 5'b0});
    fout_nxt.side = side_r;
  end

  always_ff @(posedge clk) begin
    if (stage_en[1]) begin
      fout_r <= fout_nxt;
    end
  end

  assign fout = fout_r;

endmodule

// File: design/tfm_div.sv
`timescale 1ns / 1ps
// Pipelined restoring divider for the interpolation fraction, two quotient
// bits per stage. Depends on tfm_pkg.

module tfm_div (
  input  logic                              clk,
  input  logic [tfm_pkg::DIV_STAGES-1:0]    stage_en,
  input  tfm_pkg::front_out_t               fin,
  output tfm_pkg::div_word_t                dout
);

  localparam int QIDX_W = $clog2(tfm_pkg::QUO_W);

  tfm_pkg::div_word_t stg_r   [tfm_pkg::DIV_STAGES];
  tfm_pkg::div_word_t stg_in  [tfm_pkg::DIV_STAGES];
  tfm_pkg::div_word_t stg_nxt [tfm_pkg::DIV_STAGES];

  assign stg_in[0] = '{rem: fin.num, dvsr: fin.dvsr, quo: '0, side: fin.side};

  for (genvar s = 0; s < tfm_pkg::DIV_STAGES; s++) begin : g_stage
    if (s > 0) begin : g_link
      assign stg_in[s] = stg_r[s-1];
    end

    // The quotient never exceeds the segment width in steps, so the top
    // trial subtraction cannot overflow the remainder.
    always_comb begin
      logic [QIDX_W-1:0]         bit_idx;
      logic [tfm_pkg::NUM_W-1:0] sub;
      stg_nxt[s] = stg_in[s];
      for (int k = 0; k < tfm_pkg::DIV_BITS_PER_STAGE; k++) begin
        bit_idx = QIDX_W'(tfm_pkg::QUO_W - 1 - s * tfm_pkg::DIV_BITS_PER_STAGE - k);
        sub = tfm_pkg::NUM_W'(stg_nxt[s].dvsr) << bit_idx;
        if (stg_nxt[s].rem >= sub) begin
          stg_nxt[s].rem          = stg_nxt[s].rem - sub;
          stg_nxt[s].quo[bit_idx] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (stage_en[s]) begin
        stg_r[s] <= stg_nxt[s];
      end
    end
  end

  assign dout = stg_r[tfm_pkg::DIV_STAGES-1];

endmodule

// File: design/tfm_fuse.sv
`timescale 1ns / 1ps
// Fusion back end: thermistor temperature assembly, min/max/PCB selection,
// spread check and alarm level in three stages. Depends on tfm_pkg.

module tfm_fuse (
  input  logic                                   clk,
  input  logic [2:0]                             stage_en,
  input  tfm_pkg::src_temps_t                    src,
  input  tfm_pkg::div_word_t                     r1,
  input  tfm_pkg::div_word_t                     r2,
  input  logic signed [tfm_pkg::CFG_W-1:0]       warn_thr,
  input  logic signed [tfm_pkg::CFG_W-1:0]       crit_thr,
  input  logic [tfm_pkg::CFG_W-1:0]              spread_lim,
  output logic signed [tfm_pkg::TEMP_W-1:0]      digital_temp,
  output logic signed [tfm_pkg::NTC_TEMP_W-1:0]  ntc1_temp,
  output logic                                   ntc1_valid,
  output logic signed [tfm_pkg::NTC_TEMP_W-1:0]  ntc2_temp,
  output logic                                   ntc2_valid,
  output logic signed [tfm_pkg::TEMP_W-1:0]      die_temp,
  output logic [2:0]                             valid_count,
  output logic [tfm_pkg::TEMP_W-1:0]             spread,
  output logic                                   spread_ok,
  output logic signed [tfm_pkg::TEMP_W-1:0]      pcb_temp,
  output logic [1:0]                             alarm_level
);

  function automatic logic signed [tfm_pkg::NTC_TEMP_W-1:0] ntc_temp(
    input tfm_pkg::div_word_t r
  );
    logic [tfm_pkg::TEMP_W-1:0]             off;
    logic signed [tfm_pkg::NTC_TEMP_W-1:0]  t;
    off = tfm_pkg::TEMP_W'({r.side.lo, 7'b0}) + tfm_pkg::TEMP_W'({r.side.lo, 5'b0})
        + tfm_pkg::TEMP_W'(r.quo);
    if (!r.side.valid) begin
      t = '0;
    end else if (r.side.cold) begin
      t = tfm_pkg::NTC_COLD_T;
    end else if (r.side.hot) begin
      t = tfm_pkg::NTC_HOT_T;
    end else begin
      t = off[tfm_pkg::NTC_TEMP_W-1:0] + tfm_pkg::NTC_COLD_T;
    end
    return t;
  endfunction

  // Assembly stage.
  tfm_pkg::src_temps_t                   src_a_r;
  logic signed [tfm_pkg::NTC_TEMP_W-1:0] t1_a_r;
  logic signed [tfm_pkg::NTC_TEMP_W-1:0] t2_a_r;
  logic                                  v1_a_r;
  logic                                  v2_a_r;

  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      src_a_r <= src;
      t1_a_r  <= ntc_temp(r1);
      t2_a_r  <= ntc_temp(r2);
      v1_a_r  <= r1.side.valid;
      v2_a_r  <= r2.side.valid;
    end
  end

  // Selection stage.
  tfm_pkg::src_temps_t                   src_b_r;
  logic signed [tfm_pkg::NTC_TEMP_W-1:0] t1_b_r;
  logic signed [tfm_pkg::NTC_TEMP_W-1:0] t2_b_r;
  logic                                  v1_b_r;
  logic                                  v2_b_r;
  logic signed [tfm_pkg::TEMP_W-1:0]     mn_b_r;
  logic signed [tfm_pkg::TEMP_W-1:0]     mx_b_r;
  logic signed [tfm_pkg::TEMP_W-1:0]     pcb_b_r;
  logic signed [tfm_pkg::TEMP_W-1:0]     mn_b_nxt;
  logic signed [tfm_pkg::TEMP_W-1:0]     mx_b_nxt;
  logic signed [tfm_pkg::TEMP_W-1:0]     pcb_b_nxt;

  always_comb begin
    logic signed [tfm_pkg::TEMP_W-1:0] e1;
    logic signed [tfm_pkg::TEMP_W-1:0] e2;
    logic signed [tfm_pkg::TEMP_W-1:0] mn_s;
    logic signed [tfm_pkg::TEMP_W-1:0] mx_s;
    logic signed [tfm_pkg::TEMP_W-1:0] mn_n;
    logic signed [tfm_pkg::TEMP_W-1:0] mx_n;
    logic                              any_n;
    e1 = {t1_a_r[tfm_pkg::NTC_TEMP_W-1], t1_a_r};
    e2 = {t2_a_r[tfm_pkg::NTC_TEMP_W-1], t2_a_r};
    mn_s = (src_a_r.dig < src_a_r.die) ? src_a_r.dig : src_a_r.die;
    mx_s = (src_a_r.dig > src_a_r.die) ? src_a_r.dig : src_a_r.die;
    // Thermistor pair reduced on its own, then merged with the fixed sources.
    any_n = v1_a_r || v2_a_r;
    if (v1_a_r && v2_a_r) begin
      mn_n = (e1 < e2) ? e1 : e2;
      mx_n = (e1 > e2) ? e1 : e2;
    end else if (v1_a_r) begin
      mn_n = e1;
      mx_n = e1;
    end else begin
      mn_n = e2;
      mx_n = e2;
    end
    mn_b_nxt  = (any_n && mn_n < mn_s) ? mn_n : mn_s;
    mx_b_nxt  = (any_n && mx_n > mx_s) ? mx_n : mx_s;
    pcb_b_nxt = (any_n && mx_n > src_a_r.dig) ? mx_n : src_a_r.dig;
  end

  always_ff @(posedge clk) begin
    if (stage_en[1]) begin
      src_b_r <= src_a_r;
      t1_b_r  <= t1_a_r;
      t2_b_r  <= t2_a_r;
      v1_b_r  <= v1_a_r;
      v2_b_r  <= v2_a_r;
      mn_b_r  <= mn_b_nxt;
      mx_b_r  <= mx_b_nxt;
      pcb_b_r <= pcb_b_nxt;
    end
  end

  // Result stage.
  logic signed [tfm_pkg::TEMP_W:0]       sp_full;
  tfm_pkg::alarm_t                       level_nxt;
  logic signed [tfm_pkg::TEMP_W-1:0]     digital_temp_r;
  logic signed [tfm_pkg::NTC_TEMP_W-1:0] ntc1_temp_r;
  logic                                  ntc1_valid_r;
  logic signed [tfm_pkg::NTC_TEMP_W-1:0] ntc2_temp_r;
  logic                                  ntc2_valid_r;
  logic signed [tfm_pkg::TEMP_W-1:0]     die_temp_r;
  logic [2:0]                            valid_count_r;
  logic [tfm_pkg::TEMP_W-1:0]            spread_r;
  logic                                  spread_ok_r;
  logic signed [tfm_pkg::TEMP_W-1:0]     pcb_temp_r;
  tfm_pkg::alarm_t                       alarm_level_r;

  always_comb begin
    sp_full = {mx_b_r[tfm_pkg::TEMP_W-1], mx_b_r} - {mn_b_r[tfm_pkg::TEMP_W-1], mn_b_r};
    if (pcb_b_r >= crit_thr) begin
      level_nxt = tfm_pkg::ALARM_CRIT;
    end else if (pcb_b_r >= warn_thr) begin
      level_nxt = tfm_pkg::ALARM_WARN;
    end else begin
      level_nxt = tfm_pkg::ALARM_NORMAL;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_en[2]) begin
      digital_temp_r <= src_b_r.dig;
      die_temp_r     <= src_b_r.die;
      ntc1_temp_r    <= t1_b_r;
      ntc1_valid_r   <= v1_b_r;
      ntc2_temp_r    <= t2_b_r;
      ntc2_valid_r   <= v2_b_r;
      valid_count_r  <= 3'd2 + 3'(v1_b_r) + 3'(v2_b_r);
      spread_r       <= sp_full[tfm_pkg::TEMP_W-1:0];
      spread_ok_r    <= sp_full[tfm_pkg::TEMP_W-1:0] <= spread_lim;
      pcb_temp_r     <= pcb_b_r;
      alarm_level_r  <= level_nxt;
    end
  end

  assign digital_temp = digital_temp_r;
  assign ntc1_temp    = ntc1_temp_r;
  assign ntc1_valid   = ntc1_valid_r;
  assign ntc2_temp    = ntc2_temp_r;
  assign ntc2_valid   = ntc2_valid_r;
  assign die_temp     = die_temp_r;
  assign valid_count  = valid_count_r;
  assign spread       = spread_r;
  assign spread_ok    = spread_ok_r;
  assign pcb_temp     = pcb_temp_r;
  assign alarm_level  = alarm_level_r;

endmodule

// File: design/temperature_fusion_monitor.sv
`timescale 1ns / 1ps
// Temperature fusion monitor top level. Uses tfm_pkg, tfm_ntc_front, tfm_div, tfm_fuse.
// Nine register stages. While out_ready holds, the pipe takes one transaction
// per cycle, a rate set by the fully pipelined divider.
// Reset (rst_n, synchronous, active low) empties the pipe and loads the default
// thresholds; there is no clearing pass, so the block is ready once reset is released.
// Every stage keeps its own valid bit and moves when the stage after it is free,
// so bubbles collapse and a stalled output never drops or repeats a result.

module temperature_fusion_monitor (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // Input channel: one sample set per transaction.
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [15:0]                            in_digital_raw,
  input  logic [tfm_pkg::CODE_W-1:0]             in_ntc1_raw,
  input  logic [tfm_pkg::CODE_W-1:0]             in_ntc2_raw,
  input  logic [15:0]                            in_die_raw,
  // Result channel.
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [tfm_pkg::TEMP_W-1:0]      out_digital_temp,
  output logic signed [tfm_pkg::NTC_TEMP_W-1:0]  out_ntc1_temp,
  output logic                                   out_ntc1_valid,
  output logic signed [tfm_pkg::NTC_TEMP_W-1:0]  out_ntc2_temp,
  output logic                                   out_ntc2_valid,
  output logic signed [tfm_pkg::TEMP_W-1:0]      out_die_temp,
  output logic [2:0]                             out_valid_count,
  output logic [tfm_pkg::TEMP_W-1:0]             out_spread,
  output logic                                   out_spread_ok,
  output logic signed [tfm_pkg::TEMP_W-1:0]      out_pcb_temp,
  output logic [1:0]                             out_alarm_level,
  // Configuration write port.
  input  logic                                   cfg_we,
  input  logic [tfm_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [tfm_pkg::CFG_W-1:0]              cfg_wdata
);

  localparam int NS = tfm_pkg::NUM_STAGES;
  localparam int SIDE_DEPTH = tfm_pkg::ST_FINAL;

  // ---------------------------------------------------------------------------
  // Configuration registers, read directly by the back end. The user must write them only
  // while the pipe is idle; the block does not check it. Index three decodes to nothing.
  // ---------------------------------------------------------------------------
  logic signed [tfm_pkg::CFG_W-1:0] warn_thr_r;
  logic signed [tfm_pkg::CFG_W-1:0] crit_thr_r;
  logic [tfm_pkg::CFG_W-1:0]        spread_lim_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      warn_thr_r   <= tfm_pkg::WARN_RESET;
      crit_thr_r   <= tfm_pkg::CRIT_RESET;
      spread_lim_r <= tfm_pkg::SPREAD_RESET;
    end else if (cfg_we) begin
      unique case (tfm_pkg::cfg_idx_t'(cfg_index))
        tfm_pkg::CFG_WARN:   warn_thr_r   <= cfg_wdata;
        tfm_pkg::CFG_CRIT:   crit_thr_r   <= cfg_wdata;
        tfm_pkg::CFG_SPREAD: spread_lim_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline control. A stage loads when it is empty or when the stage after it
  // is loading too; the output stage loads when its result is empty or taken.
  // ---------------------------------------------------------------------------
  logic [NS-1:0] vld_r;
  logic [NS-1:0] vld_nxt;
  logic [NS-1:0] stage_en;

  always_comb begin
    stage_en[NS-1] = !vld_r[NS-1] || out_ready;
    for (int k = NS - 2; k >= 0; k--) begin
      stage_en[k] = !vld_r[k] || stage_en[k+1];
    end
    for (int k = 0; k < NS; k++) begin
      if (stage_en[k]) begin
        vld_nxt[k] = (k == 0) ? in_valid : vld_r[(k == 0) ? 0 : k - 1];
      end else begin
        vld_nxt[k] = vld_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_ready  = stage_en[0];
  assign out_valid = vld_r[NS-1];

  // ---------------------------------------------------------------------------
  // The digital and die sensor words only need field extraction; they ride a
  // side line until the back end meets them with the thermistor results.
  // The die reading is in 1/8 degC, so two zero bits scale it to 1/32 degC.
  // ---------------------------------------------------------------------------
  tfm_pkg::src_temps_t src_in;
  tfm_pkg::src_temps_t side_r [SIDE_DEPTH];

  assign src_in.dig = in_digital_raw[15:2];
  assign src_in.die = {in_die_raw[15:4], 2'b00};

  always_ff @(posedge clk) begin
    for (int k = 0; k < SIDE_DEPTH; k++) begin
      if (stage_en[k]) begin
        side_r[k] <= (k == 0) ? src_in : side_r[(k == 0) ? 0 : k - 1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Two thermistor lanes: segment search and lookup, then the interpolation
  // divide, one quotient bit pair per stage.
  // ---------------------------------------------------------------------------
  tfm_pkg::front_out_t fout1;
  tfm_pkg::front_out_t fout2;
  tfm_pkg::div_word_t  dout1;
  tfm_pkg::div_word_t  dout2;

  tfm_ntc_front u_front1 (
    .clk      (clk),
    .stage_en (stage_en[tfm_pkg::ST_LOOKUP:tfm_pkg::ST_SEARCH]),
    .code     (in_ntc1_raw),
    .fout     (fout1)
  );

  tfm_ntc_front u_front2 (
    .clk      (clk),
    .stage_en (stage_en[tfm_pkg::ST_LOOKUP:tfm_pkg::ST_SEARCH]),
    .code     (in_ntc2_raw),
    .fout     (fout2)
  );

  tfm_div u_div1 (
    .clk      (clk),
    .stage_en (stage_en[tfm_pkg::ST_FINAL-1:tfm_pkg::ST_DIV0]),
    .fin      (fout1),
    .dout     (dout1)
  );

  tfm_div u_div2 (
    .clk      (clk),
    .stage_en (stage_en[tfm_pkg::ST_FINAL-1:tfm_pkg::ST_DIV0]),
    .fin      (fout2),
    .dout     (dout2)
  );

  // ---------------------------------------------------------------------------
  // Back end: thermistor temperatures, spread over the valid sources, PCB
  // temperature and alarm level. Its last stage is the output register.
  // ---------------------------------------------------------------------------
  tfm_fuse u_fuse (
    .clk          (clk),
    .stage_en     (stage_en[tfm_pkg::ST_OUT:tfm_pkg::ST_FINAL]),
    .src          (side_r[SIDE_DEPTH-1]),
    .r1           (dout1),
    .r2           (dout2),
    .warn_thr     (warn_thr_r),
    .crit_thr     (crit_thr_r),
    .spread_lim   (spread_lim_r),
    .digital_temp (out_digital_temp),
    .ntc1_temp    (out_ntc1_temp),
    .ntc1_valid   (out_ntc1_valid),
    .ntc2_temp    (out_ntc2_temp),
    .ntc2_valid   (out_ntc2_valid),
    .die_temp     (out_die_temp),
    .valid_count  (out_valid_count),
    .spread       (out_spread),
    .spread_ok    (out_spread_ok),
    .pcb_temp     (out_pcb_temp),
    .alarm_level  (out_alarm_level)
  );

endmodule
